// File: rtl/pfcb_pkg.sv
`default_nettype none
package pfcb_pkg;

  // Pixel held as four 16-bit unorm channels: 0 red, 1 green, 2 blue, 3 alpha
  typedef logic [3:0][15:0] pix_t;

  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 16;
  localparam logic [15:0] UnormMax = 16'hFFFF;

  // Pixel format codes; code three behaves like rgba16
  localparam logic [1:0] FMT_RGB8 = 2'd0;
  localparam logic [1:0] FMT_RGBA8 = 2'd1;
  localparam logic [1:0] FMT_RGBA16 = 2'd2;

  // Blend mode codes; code three behaves like keep source
  localparam logic [1:0] MODE_SRC = 2'd0;
  localparam logic [1:0] MODE_DST = 2'd1;
  localparam logic [1:0] MODE_OVER = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SOURCE_SELECT = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_SOURCE_FORMAT = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_DEST_FORMAT = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_BLEND_MODE = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_CONST_RED = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_CONST_GREEN = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_CONST_BLUE = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_CONST_ALPHA = 4'd7;

  // Widen a packed word pair into 16-bit unorm channels
  function automatic pix_t unpack(input logic [1:0] fmt, input logic [31:0] lo,
                                  input logic [31:0] hi);
    pix_t p;
    if (fmt == FMT_RGB8 || fmt == FMT_RGBA8) begin
      for (int k = 0; k < 4; k++) begin
        p[k] = {lo[8*k +: 8], lo[8*k +: 8]};
      end
      if (fmt == FMT_RGB8) begin
        p[3] = UnormMax;
      end
    end else begin
      p[0] = lo[15:0];
      p[1] = lo[31:16];
      p[2] = hi[15:0];
      p[3] = hi[31:16];
    end
    return p;
  endfunction

  // round(num / 65535) half-up, exact for num up to 65535*65535
  function automatic logic [15:0] div65535_round(input logic [31:0] num);
    logic [32:0] x;
    logic [33:0] t;
    x = {1'b0, num} + 33'd32767;
    t = {1'b0, x} + {17'd0, x[32:16]} + 34'd1;
    return t[31:16];
  endfunction

  // 16-bit unorm to 8-bit unorm, round half-up
  function automatic logic [7:0] narrow8(input logic [15:0] c);
    logic [23:0] scaled;
    logic [15:0] q;
    scaled = {c, 8'd0} - {8'd0, c};
    q = div65535_round({8'd0, scaled});
    return q[7:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/pixel_format_convert_blend_top.sv
// An accepted input request moves through each stage register to the output.
// Throughput: one pixel per cycle unless the output stalls; every stage has its
// own valid bit and each stage advances on its own, so a bubble closes up and a
// stall loses nothing. The 16x16 multipliers of stage two set the stage depth.
// Reset (rst_ni low, asynchronous): pipeline empties, registers return to
// their defaults (rgba8 in and out, source over, opaque black constant).
`default_nettype none
module pixel_format_convert_blend_top
  import pfcb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // pixel input channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [31:0]         src_word_lo_i,
  input  wire logic [31:0]         src_word_hi_i,
  input  wire logic [31:0]         dst_word_lo_i,
  input  wire logic [31:0]         dst_word_hi_i,
  // pixel output channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [31:0]              out_word_lo_o,
  output logic [31:0]              out_word_hi_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always accepted; an index
  // past the last register is accepted and dropped.
  // ---------------------------------------------------------------------------
  logic        source_select_q;
  logic [1:0]  source_format_q;
  logic [1:0]  dest_format_q;
  logic [1:0]  blend_mode_q;
  pix_t        const_color_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_select_q <= 1'b0;
      source_format_q <= FMT_RGBA8;
      dest_format_q   <= FMT_RGBA8;
      blend_mode_q    <= MODE_OVER;
      const_color_q   <= {UnormMax, 16'd0, 16'd0, 16'd0};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SOURCE_SELECT: source_select_q  <= cfg_data_i[0];
        REG_SOURCE_FORMAT: source_format_q  <= cfg_data_i[1:0];
        REG_DEST_FORMAT:   dest_format_q    <= cfg_data_i[1:0];
        REG_BLEND_MODE:    blend_mode_q     <= cfg_data_i[1:0];
        REG_CONST_RED:     const_color_q[0] <= cfg_data_i;
        REG_CONST_GREEN:   const_color_q[1] <= cfg_data_i;
        REG_CONST_BLUE:    const_color_q[2] <= cfg_data_i;
        REG_CONST_ALPHA:   const_color_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Per-stage flow control: a stage takes a new request when it is empty or
  // its content moves on in the same cycle.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready, out_stage_ready;

  assign out_stage_ready = !out_valid_q || out_ready_i;
  assign s3_ready        = !s3_valid_q || out_stage_ready;
  assign s2_ready        = !s2_valid_q || s3_ready;
  assign s1_ready        = !s1_valid_q || s2_ready;
  assign in_ready_o      = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready)        s1_valid_q  <= in_valid_i;
      if (s2_ready)        s2_valid_q  <= s1_valid_q;
      if (s3_ready)        s3_valid_q  <= s2_valid_q;
      if (out_stage_ready) out_valid_q <= s3_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: widen both pixels to 16-bit unorm, pick the source, form 1 - sa.
  // ---------------------------------------------------------------------------
  pix_t        src_d, dst_d;
  logic [15:0] inv_d;
  pix_t        s1_src_q, s1_dst_q;
  logic [15:0] s1_inv_q;

  always_comb begin
    src_d = source_select_q ? const_color_q
                            : unpack(source_format_q, src_word_lo_i, src_word_hi_i);
    dst_d = unpack(dest_format_q, dst_word_lo_i, dst_word_hi_i);
    inv_d = UnormMax - src_d[3];
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_src_q <= src_d;
      s1_dst_q <= dst_d;
      s1_inv_q <= inv_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: scale each destination channel by 1 - sa.
  // ---------------------------------------------------------------------------
  logic [3:0][31:0] prod_d;
  logic [3:0][31:0] s2_prod_q;
  pix_t             s2_src_q, s2_dst_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_d[k] = s1_dst_q[k] * s1_inv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_prod_q <= prod_d;
      s2_src_q  <= s1_src_q;
      s2_dst_q  <= s1_dst_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: divide by 65535 with rounding, add the source, saturate, then
  // select the blend mode result.
  // ---------------------------------------------------------------------------
  pix_t        res_d;
  pix_t        over_pix;
  pix_t        s3_res_q;
  logic [16:0] over_sum;

  always_comb begin
    over_pix = '0;
    over_sum = '0;
    for (int k = 0; k < 4; k++) begin
      over_sum    = {1'b0, s2_src_q[k]} + {1'b0, div65535_round(s2_prod_q[k])};
      over_pix[k] = over_sum[16] ? UnormMax : over_sum[15:0];
    end
    if (blend_mode_q == MODE_DST) begin
      res_d = s2_dst_q;
    end else if (blend_mode_q == MODE_OVER) begin
      res_d = over_pix;
    end else begin
      res_d = s2_src_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      s3_res_q <= res_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: narrow to the destination format and pack; this is the output
  // register, held while the consumer stalls.
  // ---------------------------------------------------------------------------
  logic [31:0] out_lo_d, out_hi_d;
  logic [31:0] out_lo_q, out_hi_q;
  logic [3:0][7:0] narrow_ch;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      narrow_ch[k] = narrow8(s3_res_q[k]);
    end
    out_hi_d = '0;
    if (dest_format_q == FMT_RGB8) begin
      out_lo_d = {8'd0, narrow_ch[2], narrow_ch[1], narrow_ch[0]};
    end else if (dest_format_q == FMT_RGBA8) begin
      out_lo_d = narrow_ch;
    end else begin
      out_lo_d = {s3_res_q[1], s3_res_q[0]};
      out_hi_d = {s3_res_q[3], s3_res_q[2]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_stage_ready && s3_valid_q) begin
      out_lo_q <= out_lo_d;
      out_hi_q <= out_hi_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_word_lo_o = out_lo_q;
  assign out_word_hi_o = out_hi_q;

endmodule
`default_nettype wire

// File: rtl/pfcb_checker.sv
`default_nettype none
module pfcb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_word_lo_o,
  input wire logic [31:0] out_word_hi_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_word_lo_o) && $stable(out_word_hi_o))
    else $error("output request changed while stalled");

  // result leaves only through a handshake
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("output request dropped without handshake");

  // input backpressure only arises from a full, stalled output
  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked while output side can drain");

  // reset empties the pipeline by the following edge
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && in_ready_o)
    else $error("pipeline not empty after reset");

endmodule

bind pixel_format_convert_blend_top pfcb_checker u_pfcb_checker (.*);
`default_nettype wire
